[design/kms_pkg.sv]
// Package: shared constants, key codes and character lookup functions for the keypad scanner.
`default_nettype none
package kms_pkg;

   // Tick counter width and compare width against the 16-bit thresholds
   localparam int TICK_WIDTH = 16;
   localparam int THRESH_WIDTH = 16;
   localparam int CMP_WIDTH = (TICK_WIDTH > THRESH_WIDTH) ? TICK_WIDTH : THRESH_WIDTH;

   // Key codes
   localparam logic [3:0] KEY_STAR = 4'd9;
   localparam logic [3:0] KEY_HASH = 4'd11;
   localparam logic [3:0] KEY_LAST = 4'd11;
   localparam logic [3:0] KEY_NONE = 4'd15;

   // Configuration register indexes
   localparam logic [1:0] CSR_ENABLE = 2'd0;
   localparam logic [1:0] CSR_MULTITAP = 2'd1;
   localparam logic [1:0] CSR_DEBOUNCE = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT = 2'd3;

   // Command codes
   localparam logic CMD_SCAN = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Number of characters on each key
   function automatic logic [2:0] key_len(input logic [3:0] key);
      logic [2:0] len;
      case (key)
         4'd0, 4'd9, 4'd11: len = 3'd1;
         4'd6, 4'd8:        len = 3'd5;
         4'd10:             len = 3'd2;
         default:           len = 3'd4;
      endcase
      return len;
   endfunction

   // Position of the digit within each key's character list
   function automatic logic [2:0] digit_pos(input logic [3:0] key);
      logic [2:0] pos;
      case (key)
         4'd6, 4'd8:                       pos = 3'd4;
         4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd7: pos = 3'd3;
         default:                          pos = 3'd0;
      endcase
      return pos;
   endfunction

   // Character ROM: out-of-range index selects the first character
   function automatic logic [7:0] char_of(input logic [3:0] key, input logic [2:0] idx);
      logic [2:0] sel;
      logic [7:0] code;
      sel = (idx >= key_len(key)) ? 3'd0 : idx;
      code = 8'h00;
      case (key)
         4'd0:  code = "1";
         4'd1:  case (sel) 3'd0: code = "A"; 3'd1: code = "B"; 3'd2: code = "C";
                   default: code = "2"; endcase
         4'd2:  case (sel) 3'd0: code = "D"; 3'd1: code = "E"; 3'd2: code = "F";
                   default: code = "3"; endcase
         4'd3:  case (sel) 3'd0: code = "G"; 3'd1: code = "H"; 3'd2: code = "I";
                   default: code = "4"; endcase
         4'd4:  case (sel) 3'd0: code = "J"; 3'd1: code = "K"; 3'd2: code = "L";
                   default: code = "5"; endcase
         4'd5:  case (sel) 3'd0: code = "M"; 3'd1: code = "N"; 3'd2: code = "O";
                   default: code = "6"; endcase
         4'd6:  case (sel) 3'd0: code = "P"; 3'd1: code = "Q"; 3'd2: code = "R";
                   3'd3: code = "S"; default: code = "7"; endcase
         4'd7:  case (sel) 3'd0: code = "T"; 3'd1: code = "U"; 3'd2: code = "V";
                   default: code = "8"; endcase
         4'd8:  case (sel) 3'd0: code = "W"; 3'd1: code = "X"; 3'd2: code = "Y";
                   3'd3: code = "Z"; default: code = "9"; endcase
         4'd9:  code = "*";
         4'd10: code = (sel == 3'd0) ? "0" : " ";
         4'd11: code = "#";
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

[design/keypad_multitap_scanner_unit.sv]
// Top level: 4x3 keypad scanner with debounce, multi-tap letter entry and read-out.
// Latency: a request beat's result is presented on rsp_ the cycle after it is accepted.
// Throughput: one request beat per cycle unless rsp_tready stalls; the scan state updates as each
// beat is taken, and the result register accepts a new beat in the same cycle its held beat is taken.
// Reset: synchronous, active high; stops scanning, drives row 0 and restores the
// configuration defaults (debounce 20 ticks, multi-tap timeout 1000 ticks).
`default_nettype none
module keypad_multitap_scanner_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [2:0] col_lines, [3] time_tick, [7:4] zero
   input  wire logic        req_tuser,   // [0] command
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [3:0] row_drive, [4] key_ready, [5] char_valid,
                                         // [13:6] char_code, [14] preview_valid,
                                         // [22:15] preview_code, [23] tone_valid,
                                         // [27:24] tone_key, [31:28] zero
   // configuration write port
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   typedef enum logic [2:0] {
      PH_STOP     = 3'd0,
      PH_IDLE     = 3'd1,
      PH_PRESS_DB = 3'd2,
      PH_DECODE   = 3'd3,
      PH_TAP      = 3'd4,
      PH_WAIT_REL = 3'd5,
      PH_REL_DB   = 3'd6
   } phase_type;

   localparam int TW = kms_pkg::TICK_WIDTH;
   localparam int CW = kms_pkg::CMP_WIDTH;

   // State and configuration registers
   phase_type       phase_ff, phase_in;
   logic [3:0]      row_ff, row_in;
   logic [3:0]      cur_key_ff, cur_key_in;
   logic [3:0]      prev_key_ff, prev_key_in;
   logic [2:0]      tap_cnt_ff, tap_cnt_in;
   logic            ready_ff, ready_in;
   logic            pending_ff, pending_in;
   logic [TW-1:0]   db_cnt_ff, db_cnt_in;
   logic [TW-1:0]   tap_tmr_ff, tap_tmr_in;
   logic            mt_mode_ff, mt_mode_in;
   logic [15:0]     db_ticks_ff, db_ticks_in;
   logic [15:0]     timeout_ff, timeout_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [31:0]     rsp_data_ff, rsp_data_in;

   // Beat fields and step results
   logic            accept;
   logic            cmd;
   logic [2:0]      cols;
   logic            tick;
   logic            pressed;
   logic [TW-1:0]   db_cnt_t, tap_tmr_t;
   logic [3:0]      shifted;
   logic [1:0]      row_idx, col_idx;
   logic [3:0]      key_dec;
   logic [2:0]      tap_next;
   logic            cv, pv, tv;
   logic [7:0]      cc, pc;
   logic [3:0]      tk;
   logic [2:0]      rd_idx;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = req_tuser;
   assign cols       = req_tdata[2:0];
   assign tick       = req_tdata[3];
   assign pressed    = (cols != 3'd0);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Saturating tick counters, advanced before the step acts
   assign db_cnt_t  = (tick && (db_cnt_ff != {TW{1'b1}})) ? db_cnt_ff + 1'b1 : db_cnt_ff;
   assign tap_tmr_t = (tick && (tap_tmr_ff != {TW{1'b1}})) ? tap_tmr_ff + 1'b1 : tap_tmr_ff;

   // Row rotation and key decode, lowest column wins
   assign shifted = {row_ff[2:0], 1'b0};
   always_comb begin
      if (row_ff[0])      row_idx = 2'd0;
      else if (row_ff[1]) row_idx = 2'd1;
      else if (row_ff[2]) row_idx = 2'd2;
      else                row_idx = 2'd3;
      if (cols[0])        col_idx = 2'd0;
      else if (cols[1])   col_idx = 2'd1;
      else if (cols[2])   col_idx = 2'd2;
      else                col_idx = 2'd0;
   end
   assign key_dec = {1'b0, row_idx, 1'b0} + {2'b00, row_idx} + {2'b00, col_idx};

   // Next tap count on a repeat tap of the same key
   assign tap_next = (tap_cnt_ff + 3'd1 == kms_pkg::key_len(cur_key_ff)) ?
                     3'd0 : tap_cnt_ff + 3'd1;

   assign rd_idx = mt_mode_ff ? tap_cnt_ff : kms_pkg::digit_pos(cur_key_ff);

   // Step logic and configuration writes
   always_comb begin
      phase_in    = phase_ff;
      row_in      = row_ff;
      cur_key_in  = cur_key_ff;
      prev_key_in = prev_key_ff;
      tap_cnt_in  = tap_cnt_ff;
      ready_in    = ready_ff;
      pending_in  = pending_ff;
      db_cnt_in   = db_cnt_ff;
      tap_tmr_in  = tap_tmr_ff;
      mt_mode_in  = mt_mode_ff;
      db_ticks_in = db_ticks_ff;
      timeout_in  = timeout_ff;
      cv = 1'b0; cc = 8'h00; pv = 1'b0; pc = 8'h00; tv = 1'b0; tk = 4'd0;

      if (accept) begin
         db_cnt_in  = db_cnt_t;
         tap_tmr_in = tap_tmr_t;
         if (cmd == kms_pkg::CMD_READ) begin
            if (ready_ff) begin
               cv         = 1'b1;
               cc         = kms_pkg::char_of(cur_key_ff, rd_idx);
               ready_in   = 1'b0;
               tap_cnt_in = 3'd0;
            end
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  // commit a timed-out tap, then hold row on a press or rotate
                  if (pending_ff && ((CW)'(tap_tmr_t) >= (CW)'(timeout_ff))) begin
                     pending_in  = 1'b0;
                     prev_key_in = kms_pkg::KEY_NONE;
                     ready_in    = 1'b1;
                  end
                  if (pressed) begin
                     ready_in  = 1'b0;
                     phase_in  = PH_PRESS_DB;
                     db_cnt_in = '0;
                  end else begin
                     row_in = (shifted == 4'd0) ? 4'd1 : shifted;
                  end
               end
               PH_PRESS_DB: begin
                  if (!pressed) begin
                     phase_in = PH_IDLE;
                  end else if ((CW)'(db_cnt_t) >= (CW)'(db_ticks_ff)) begin
                     phase_in   = PH_DECODE;
                     tap_tmr_in = '0;
                  end
               end
               PH_DECODE: begin
                  cur_key_in = key_dec;
                  if (mt_mode_ff && key_dec != kms_pkg::KEY_STAR &&
                      key_dec != kms_pkg::KEY_HASH) begin
                     phase_in = PH_TAP;
                  end else begin
                     phase_in = PH_WAIT_REL;
                  end
               end
               PH_TAP: begin
                  if (prev_key_ff != cur_key_ff && pending_ff) begin
                     // different key: commit the pending letter, keep scanning
                     cur_key_in = prev_key_ff;
                     phase_in   = PH_IDLE;
                     ready_in   = 1'b1;
                     pending_in = 1'b0;
                  end else begin
                     tap_cnt_in  = (prev_key_ff == cur_key_ff) ? tap_next : 3'd0;
                     pending_in  = 1'b1;
                     prev_key_in = cur_key_ff;
                     phase_in    = PH_WAIT_REL;
                  end
               end
               PH_WAIT_REL: begin
                  if (!pressed) begin
                     phase_in  = PH_REL_DB;
                     db_cnt_in = '0;
                  end
               end
               PH_REL_DB: begin
                  if (pressed) begin
                     phase_in = PH_WAIT_REL;
                  end else if ((CW)'(db_cnt_t) >= (CW)'(db_ticks_ff)) begin
                     phase_in = PH_IDLE;
                     if (!mt_mode_ff || cur_key_ff == kms_pkg::KEY_STAR ||
                         cur_key_ff == kms_pkg::KEY_HASH) begin
                        ready_in = 1'b1;
                     end else begin
                        pv = 1'b1;
                        pc = kms_pkg::char_of(cur_key_ff, tap_cnt_ff);
                     end
                     tv = 1'b1;
                     tk = cur_key_ff;
                  end
               end
               default: begin
                  // stopped: hold everything
               end
            endcase
         end
      end

      // Configuration writes must arrive only while no beat is in flight; the block itself does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            kms_pkg::CSR_ENABLE: begin
               phase_in = csr_wdata[0] ? PH_IDLE : PH_STOP;
               ready_in = 1'b0;
            end
            kms_pkg::CSR_MULTITAP: begin
               mt_mode_in = csr_wdata[0];
               pending_in = 1'b0;
               if (csr_wdata[0]) prev_key_in = kms_pkg::KEY_NONE;
            end
            kms_pkg::CSR_DEBOUNCE: db_ticks_in = csr_wdata;
            kms_pkg::CSR_TIMEOUT:  timeout_in  = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Result register: load on accept, drop when the held beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'd0, tk, tv, pc, pv, cc, cv, ready_in, row_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_STOP;
         row_ff       <= 4'd1;
         cur_key_ff   <= 4'd0;
         prev_key_ff  <= kms_pkg::KEY_NONE;
         tap_cnt_ff   <= 3'd0;
         ready_ff     <= 1'b0;
         pending_ff   <= 1'b0;
         db_cnt_ff    <= '0;
         tap_tmr_ff   <= '0;
         mt_mode_ff   <= 1'b0;
         db_ticks_ff  <= 16'd20;
         timeout_ff   <= 16'd1000;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         row_ff       <= row_in;
         cur_key_ff   <= cur_key_in;
         prev_key_ff  <= prev_key_in;
         tap_cnt_ff   <= tap_cnt_in;
         ready_ff     <= ready_in;
         pending_ff   <= pending_in;
         db_cnt_ff    <= db_cnt_in;
         tap_tmr_ff   <= tap_tmr_in;
         mt_mode_ff   <= mt_mode_in;
         db_ticks_ff  <= db_ticks_in;
         timeout_ff   <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
